[sv/cafvg_pkg.sv]
// ----------------------------------------------------------------------------
// cafvg_pkg
// Shared types and constants of the class aware frequent value grouper.
// ----------------------------------------------------------------------------
`default_nettype none
package cafvg_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int NUM_CLASSES_DEF = 4;

  localparam int COL_W   = 16;
  localparam int VAL_W   = 32;
  localparam int LAB_W   = 2;
  localparam int SUP_W   = 7;
  localparam int ROW_W   = 6;
  localparam int NUM_W   = 16;
  localparam int CCNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 7;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_BITS    = NUM_W + COL_W + VAL_W + SUP_W + SUP_W + ROW_W + 1;
  localparam int OUT_TDATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] REG_MINSUP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINSUP1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINSUP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MINSUP3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMALLEST    = 3'd5;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIND,
    ST_COUNT,
    ST_EMIT,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

[sv/cafvg_ram.sv]
// ----------------------------------------------------------------------------
// cafvg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cafvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/class_aware_frequent_value_grouper.sv]
// ----------------------------------------------------------------------------
// class_aware_frequent_value_grouper
// Loads a column into a row RAM, then scans it per distinct value, counts
// class support and emits qualifying groups one row per item.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_axis   | in        | one row of the column, tlast on the last row
//  m_axis   | out       | one item per emitted group row, tlast ends column
//  cfg      | in        | register write, index and data
//
//  Loading accepts every row that is offered; from the last row on, input is
//  held off until the column's final item is placed. Each distinct value costs
//  two passes over the row RAM (find next value, count classes), plus a third
//  pass for a group that is emitted; a pass makes one RAM read per cycle while
//  no output stall holds it. A last find pass and a closing state end the
//  column. Output stalls hold the emit pass and the close. Reset is synchronous
//  and clears control state only; the row RAM needs no clearing.
`default_nettype none
module class_aware_frequent_value_grouper #(
  parameter int MAX_ROWS    = cafvg_pkg::MAX_ROWS_DEF,
  parameter int NUM_CLASSES = cafvg_pkg::NUM_CLASSES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // column_index, cell_value, is_missing, class_label, zero fill
  input  wire  [cafvg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire                                   s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // item_number, item_column, item_value, group_support,
  // best_class_support, row_number, group_last, zero fill
  output logic [cafvg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // has_item
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  wire                                   cfg_wr_en,
  input  wire  [cafvg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [cafvg_pkg::CFG_W-1:0]           cfg_data
);
  import cafvg_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int CW = (NW > SUP_W) ? NW : SUP_W;
  localparam int MW = VAL_W + LAB_W + 1;

  state_t state, state_next;

  logic [SUP_W-1:0]  minsup [4];
  logic [CCNT_W-1:0] class_count;
  logic [SUP_W-1:0]  smallest;

  logic [NW-1:0] rows_loaded, present_count;
  logic [NW-1:0] addr, p1, gs, emit_cnt;
  logic [NW-1:0] sup [4];
  logic          rd_v;
  logic [RW-1:0] rd_idx;
  logic          found, first;
  logic signed [VAL_W-1:0] cur, prev;
  logic [COL_W-1:0] col;
  logic [NUM_W-1:0] items_emitted;

  logic              pend_v, pend_user;
  logic [OUT_BITS-1:0] pend_data;
  logic              out_v, out_user, out_last;
  logic [OUT_BITS-1:0] out_data;

  logic [MW-1:0] rdata;
  logic          r_miss;
  logic [LAB_W-1:0] r_lab;
  logic signed [VAL_W-1:0] r_val;

  logic s_acc, wr_en, issue, consume, done, scan;
  logic match_find, match_grp, out_free, can_push, push, out_load;
  logic [CCNT_W-1:0] ncls;
  logic [CW-1:0] best;
  logic qualify, skip;
  logic [CW:0] start_sum;
  logic [NW+ROW_W-1:0] row_ext;
  logic [CW-1:0] gs_ext;
  logic [OUT_BITS-1:0] new_data;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign wr_en = s_acc && (rows_loaded < NW'(MAX_ROWS));

  cafvg_ram #(.WIDTH(MW), .DEPTH(MAX_ROWS)) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rows_loaded[RW-1:0]),
    .wdata ({s_axis_tdata[48], s_axis_tdata[50:49], s_axis_tdata[47:16]}),
    .re    (issue),
    .raddr (addr[RW-1:0]),
    .rdata (rdata)
  );

  assign r_miss = rdata[MW-1];
  assign r_lab  = rdata[VAL_W +: LAB_W];
  assign r_val  = rdata[VAL_W-1:0];

  assign ncls = (class_count < CCNT_W'(NUM_CLASSES)) ? class_count : CCNT_W'(NUM_CLASSES);

  assign match_find = rd_v && !r_miss && (first || r_val > prev);
  assign match_grp  = rd_v && !r_miss && (r_val == cur);
  assign out_free   = !out_v || m_axis_tready;
  assign can_push   = !pend_v || out_free;
  assign done       = (addr == rows_loaded) && !rd_v;
  assign scan       = (state == ST_FIND) || (state == ST_COUNT) || (state == ST_EMIT);

  always_comb begin
    best = '0;
    for (int c = 0; c < 4; c++) begin
      if ((CCNT_W'(c) < ncls) && (sup[c] != '0) &&
          (CW'(sup[c]) >= CW'(minsup[c])) && (CW'(sup[c]) > best)) begin
        best = CW'(sup[c]);
      end
    end
  end

  assign qualify   = (best != '0) && (gs < rows_loaded);
  assign start_sum = (CW + 1)'(p1) + (CW + 1)'(smallest);
  assign skip      = !found || (start_sum > (CW + 1)'(present_count));
  assign row_ext   = (NW + ROW_W)'(rd_idx);
  assign gs_ext    = CW'(gs);
  assign new_data  = {((NW)'(emit_cnt + 1'b1) == gs), row_ext[ROW_W-1:0],
                      best[SUP_W-1:0], gs_ext[SUP_W-1:0], cur, col, items_emitted};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_acc && s_axis_tlast) state_next = ST_FIND;
      end
      ST_FIND: begin
        if (done) state_next = skip ? ST_FINISH : ST_COUNT;
      end
      ST_COUNT: begin
        if (done) state_next = qualify ? ST_EMIT : ST_FIND;
      end
      ST_EMIT: begin
        if (done) state_next = ST_FIND;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == ST_LOAD);
    consume = 1'b1;
    push    = 1'b0;
    if (state == ST_EMIT && match_grp) begin
      consume = can_push;
      push    = can_push;
    end
    issue = scan && (addr < rows_loaded) && (!rd_v || consume);
    out_load = ((state == ST_EMIT) && push && pend_v) ||
               ((state == ST_FINISH) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      for (int c = 0; c < 4; c++) minsup[c] <= SUP_W'(1);
      class_count   <= CCNT_W'(4);
      smallest      <= SUP_W'(1);
      rows_loaded   <= '0;
      present_count <= '0;
      items_emitted <= '0;
      addr          <= '0;
      rd_v          <= 1'b0;
      p1            <= '0;
      first         <= 1'b1;
      found         <= 1'b0;
      pend_v        <= 1'b0;
      out_v         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MINSUP0:     minsup[0]   <= cfg_data;
          REG_MINSUP1:     minsup[1]   <= cfg_data;
          REG_MINSUP2:     minsup[2]   <= cfg_data;
          REG_MINSUP3:     minsup[3]   <= cfg_data;
          REG_CLASS_COUNT: class_count <= cfg_data[CCNT_W-1:0];
          REG_SMALLEST:    smallest    <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_v <= 1'b1;
      end else if (m_axis_tready) begin
        out_v <= 1'b0;
      end

      if (issue) begin
        addr   <= addr + 1'b1;
        rd_idx <= addr[RW-1:0];
        rd_v   <= 1'b1;
      end else if (consume) begin
        rd_v <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (s_acc) begin
            col <= s_axis_tdata[15:0];
            if (wr_en) begin
              rows_loaded <= rows_loaded + 1'b1;
              if (!s_axis_tdata[48]) present_count <= present_count + 1'b1;
            end
          end
        end
        ST_FIND: begin
          if (match_find && (!found || r_val < cur)) begin
            cur   <= r_val;
            found <= 1'b1;
          end
          if (done) begin
            addr <= '0;
            gs   <= '0;
            for (int c = 0; c < 4; c++) sup[c] <= '0;
          end
        end
        ST_COUNT: begin
          if (match_grp) begin
            gs         <= gs + 1'b1;
            sup[r_lab] <= sup[r_lab] + 1'b1;
          end
          if (done) begin
            addr     <= '0;
            emit_cnt <= '0;
            if (!qualify) begin
              p1    <= p1 + gs;
              prev  <= cur;
              first <= 1'b0;
              found <= 1'b0;
            end
          end
        end
        ST_EMIT: begin
          if (push) begin
            pend_v    <= 1'b1;
            pend_user <= 1'b1;
            pend_data <= new_data;
            emit_cnt  <= emit_cnt + 1'b1;
            if (pend_v) begin
              out_data <= pend_data;
              out_user <= pend_user;
              out_last <= 1'b0;
            end
          end
          if (done) begin
            addr          <= '0;
            p1            <= p1 + gs;
            prev          <= cur;
            first         <= 1'b0;
            found         <= 1'b0;
            items_emitted <= items_emitted + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_last <= 1'b1;
            if (pend_v) begin
              out_data <= pend_data;
              out_user <= pend_user;
            end else begin
              out_data <= {{(OUT_BITS - NUM_W - COL_W){1'b0}}, col, items_emitted};
              out_user <= 1'b0;
            end
            pend_v        <= 1'b0;
            rows_loaded   <= '0;
            present_count <= '0;
            p1            <= '0;
            first         <= 1'b1;
            found         <= 1'b0;
            addr          <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_data};
  assign m_axis_tuser  = out_user;
  assign m_axis_tlast  = out_last;

endmodule
`default_nettype wire

[sv/cafvg_checker.sv]
// ----------------------------------------------------------------------------
// cafvg_checker
// Port level checks of the grouper output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cafvg_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [cafvg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire                                m_axis_tuser,
  input wire                                m_axis_tlast
);
  import cafvg_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("empty column result without column end");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[84:32] == '0)
    else $error("empty column result carries item fields");

  a_support: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[70:64] != 7'd0 && m_axis_tdata[77:71] != 7'd0 &&
      m_axis_tdata[77:71] <= m_axis_tdata[70:64])
    else $error("class support outside group support");

endmodule

bind class_aware_frequent_value_grouper cafvg_checker u_cafvg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
